// ===== rtl/core/kpc_pkg.sv =====
// Package for the keypad calculator core: key, operator and display codes,
// datapath widths, the sequencer state type and the power-of-ten table.
// No dependencies.
package kpc_pkg;

  // Digit store depth and default digit limit
  localparam int DEPTH          = 8;
  localparam int MAX_DIGITS_DEF = 8;

  // Operand magnitude width (eight decimal digits) and datapath width
  localparam int OPW = 27;
  localparam int W   = 2 * OPW + 2;

  // Key kinds
  localparam logic [1:0] KIND_DIGIT    = 2'd0;
  localparam logic [1:0] KIND_OPERATOR = 2'd1;
  localparam logic [1:0] KIND_CANCEL   = 2'd2;
  localparam logic [1:0] KIND_RESET    = 2'd3;

  // Operator keys
  localparam logic [2:0] KEY_EQUAL = 3'd4;

  // Pending operator codes
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_ADD   = 3'd1;
  localparam logic [2:0] OP_SUB   = 3'd2;
  localparam logic [2:0] OP_DIV   = 3'd3;
  localparam logic [2:0] OP_MUL   = 3'd4;
  localparam logic [2:0] OP_EQUAL = 3'd5;

  // Display commands
  localparam logic [1:0] CMD_DIGIT = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_SIGN  = 2'd2;
  localparam logic [1:0] CMD_ERROR = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CONV_A,
    ST_CONV_B,
    ST_ADD,
    ST_NEG,
    ST_MUL,
    ST_DIV,
    ST_CHECK,
    ST_EXTRACT,
    ST_EMIT_CLR1,
    ST_EMIT_HEAD,
    ST_EMIT_DIG,
    ST_EMIT_CLR2,
    ST_EMIT_ONE
  } state_e;

  // Adder request and response
  typedef struct packed {
    logic [W-1:0] x;
    logic [W-1:0] y;
    logic         sub;
  } alu_req_t;

  typedef struct packed {
    logic [W-1:0] sum;
    logic         borrow;
  } alu_rsp_t;

  // 10 to the power n, for n up to 9; larger n also give 10^9
  function automatic logic [W-1:0] pow10(input logic [3:0] n);
    logic [W-1:0] p;
    case (n)
      4'd0:    p = W'(1);
      4'd1:    p = W'(10);
      4'd2:    p = W'(100);
      4'd3:    p = W'(1000);
      4'd4:    p = W'(10000);
      4'd5:    p = W'(100000);
      4'd6:    p = W'(1000000);
      4'd7:    p = W'(10000000);
      4'd8:    p = W'(100000000);
      default: p = W'(1000000000);
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/core/kpc_alu.sv =====
// Shared add/subtract unit of the keypad calculator datapath.
// Depends on kpc_pkg.
module kpc_alu (
  input  kpc_pkg::alu_req_t req_i,
  output kpc_pkg::alu_rsp_t rsp_o
);
  import kpc_pkg::*;

  logic [W:0] full;

  // Subtract as x + ~y + 1; carry out low means borrow
  always_comb begin
    if (req_i.sub) begin
      full = {1'b0, req_i.x} + {1'b0, ~req_i.y} + (W+1)'(1);
    end else begin
      full = {1'b0, req_i.x} + {1'b0, req_i.y};
    end
    rsp_o.sum    = full[W-1:0];
    rsp_o.borrow = req_i.sub & ~full[W];
  end

endmodule

// ===== rtl/core/decimal_keypad_calculator_core.sv =====
// Keypad calculator core. Digit, cancel and plain operator keys pass through
// decode to their display request; a computing operator key uses the shared
// adder to convert both operands digit by digit, add, subtract, multiply or
// divide, check the digit limit, extract result digits, then emit its requests.
// One key is held at a time. Reset (rst_ni low, asynchronous) empties both
// operands, clears the pending operator and the sign; digit stores keep data.
// Depends on kpc_pkg and kpc_alu.
module decimal_keypad_calculator_core #(
  parameter int MAX_DIGITS = kpc_pkg::MAX_DIGITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [3:0] digit_value, [6:4] operator_key, [7] zero
  input  logic [1:0] s_axis_tuser,  // [1:0] operation
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // [3:0] display_value, [7:4] zero
  output logic [1:0] m_axis_tuser,  // [1:0] display_command
  output logic       m_axis_tlast
);
  import kpc_pkg::*;

  localparam int         LIMIT   = (MAX_DIGITS > DEPTH) ? DEPTH : MAX_DIGITS;
  localparam logic [3:0] LIMIT_C = 4'(LIMIT);

  state_e state_q, state_d;

  // Held key
  logic [1:0] kind_q;
  logic [3:0] dig_q;
  logic [2:0] key_q;

  // Architectural state
  logic [3:0] fd_q [DEPTH];
  logic [3:0] sd_q [DEPTH];
  logic [3:0] first_count_q, second_count_q;
  logic [2:0] pending_q;
  logic       sign_q;

  // Datapath
  logic [W-1:0] a_q, b_q, r_q;
  logic         ph_q, neg_q, err_q, started_q;
  logic [2:0]   idx_q;
  logic [3:0]   p_q, dg_q, len_q;
  logic [4:0]   cnt_q;

  // Output register
  logic       ov_q, olast_q;
  logic [1:0] ocmd_q;
  logic [3:0] oval_q;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  kpc_alu u_alu (
    .req_i(alu_req),
    .rsp_o(alu_rsp)
  );

  logic       accept, can_emit, emit, emit_last;
  logic [1:0] emit_cmd;
  logic [3:0] emit_val;
  logic [3:0] rd_dig;
  logic       idx_last_a, idx_last_b, plus, first_full, digit_ok;
  logic [W-1:0] rem_sh, opx, opy, pow_p;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign can_emit      = ~ov_q | m_axis_tready;

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {4'd0, oval_q};
  assign m_axis_tuser  = ocmd_q;
  assign m_axis_tlast  = olast_q;

  // Operand digit read, one index for conversion and display
  assign rd_dig     = (state_q == ST_CONV_B) ? sd_q[idx_q] : fd_q[idx_q];
  assign idx_last_a = ({1'b0, idx_q} + 4'd1) == first_count_q;
  assign idx_last_b = ({1'b0, idx_q} + 4'd1) == second_count_q;
  assign first_full = (first_count_q >= LIMIT_C) | (second_count_q >= LIMIT_C);
  assign digit_ok   = (dig_q <= 4'd9) & ~first_full;

  // Add and subtract operand order
  assign plus   = (pending_q == OP_ADD) == ~sign_q;
  assign opx    = (pending_q == OP_SUB) ? a_q : b_q;
  assign opy    = (pending_q == OP_SUB) ? b_q : a_q;
  assign rem_sh = {r_q[W-2:0], a_q[OPW-1]};
  assign pow_p  = pow10(p_q);

  // Shared adder operand selection
  always_comb begin
    alu_req = '{x: r_q, y: '0, sub: 1'b0};
    case (state_q)
      ST_CONV_A, ST_CONV_B: begin
        if (!ph_q) begin
          alu_req = '{x: {r_q[W-3:0], 2'b00}, y: r_q, sub: 1'b0};
        end else begin
          alu_req = '{x: {r_q[W-2:0], 1'b0}, y: W'(rd_dig), sub: 1'b0};
        end
      end
      ST_ADD:     alu_req = plus ? '{x: a_q, y: b_q, sub: 1'b0}
                                 : '{x: opx, y: opy, sub: 1'b1};
      ST_NEG:     alu_req = '{x: opy, y: opx, sub: 1'b1};
      ST_MUL:     alu_req = '{x: r_q, y: b_q[0] ? a_q : '0, sub: 1'b0};
      ST_DIV:     alu_req = '{x: rem_sh, y: b_q, sub: 1'b1};
      ST_CHECK:   alu_req = '{x: r_q, y: pow10(LIMIT_C), sub: 1'b1};
      ST_EXTRACT: alu_req = '{x: r_q, y: pow_p, sub: 1'b1};
      default:    alu_req = '{x: r_q, y: '0, sub: 1'b0};
    endcase
  end

  // Next state and display requests
  always_comb begin
    state_d   = state_q;
    emit      = 1'b0;
    emit_cmd  = CMD_CLEAR;
    emit_val  = 4'd0;
    emit_last = 1'b0;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_DECODE;
      ST_DECODE: begin
        unique case (kind_q)
          KIND_DIGIT:    state_d = digit_ok ? ST_EMIT_ONE : ST_IDLE;
          KIND_OPERATOR: begin
            if (key_q > KEY_EQUAL) begin
              state_d = ST_IDLE;
            end else if (pending_q == OP_NONE || pending_q == OP_EQUAL) begin
              state_d = ST_EMIT_ONE;
            end else begin
              state_d = ST_CONV_A;
            end
          end
          KIND_CANCEL:   state_d = ST_EMIT_ONE;
          default:       state_d = ST_IDLE;
        endcase
      end
      ST_CONV_A: if (first_count_q == 4'd0 || (ph_q && idx_last_a)) state_d = ST_CONV_B;
      ST_CONV_B: begin
        if (second_count_q == 4'd0 || (ph_q && idx_last_b)) begin
          unique case (pending_q)
            OP_ADD, OP_SUB: state_d = ST_ADD;
            OP_DIV:         state_d = (second_count_q == 4'd0 || (ph_q && alu_rsp.sum == '0))
                                      ? ST_EMIT_CLR1 : ST_DIV;
            default:        state_d = ST_MUL;
          endcase
        end
      end
      ST_ADD:     state_d = (!plus && alu_rsp.borrow) ? ST_NEG : ST_CHECK;
      ST_NEG:     state_d = ST_CHECK;
      ST_MUL:     if (b_q == '0) state_d = ST_CHECK;
      ST_DIV:     if (cnt_q == 5'd0) state_d = ST_CHECK;
      ST_CHECK:   state_d = alu_rsp.borrow ? ST_EXTRACT : ST_EMIT_CLR1;
      ST_EXTRACT: if (alu_rsp.borrow && p_q == 4'd0) state_d = ST_EMIT_CLR1;
      ST_EMIT_CLR1: begin
        emit = can_emit;
        if (can_emit) state_d = ST_EMIT_HEAD;
      end
      ST_EMIT_HEAD: begin
        emit     = can_emit;
        emit_cmd = err_q ? CMD_ERROR : CMD_SIGN;
        emit_val = {3'd0, sign_q & ~err_q};
        if (can_emit) state_d = err_q ? ST_EMIT_CLR2 : ST_EMIT_DIG;
      end
      ST_EMIT_DIG: begin
        emit     = can_emit;
        emit_cmd = CMD_DIGIT;
        emit_val = rd_dig;
        if (can_emit && idx_last_a) state_d = ST_EMIT_CLR2;
      end
      ST_EMIT_CLR2: begin
        emit      = can_emit;
        emit_last = 1'b1;
        if (can_emit) state_d = ST_IDLE;
      end
      ST_EMIT_ONE: begin
        emit      = can_emit;
        emit_last = 1'b1;
        emit_cmd  = (kind_q == KIND_DIGIT) ? CMD_DIGIT : CMD_CLEAR;
        emit_val  = (kind_q == KIND_DIGIT) ? dig_q : 4'd0;
        if (can_emit) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (emit) begin
      ov_q <= 1'b1;
    end else if (m_axis_tready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      ocmd_q  <= emit_cmd;
      oval_q  <= emit_val;
      olast_q <= emit_last;
    end
  end

  // Operand counts, pending operator and sign
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_count_q  <= 4'd0;
      second_count_q <= 4'd0;
      pending_q      <= OP_NONE;
      sign_q         <= 1'b0;
    end else begin
      case (state_q)
        ST_DECODE: begin
          case (kind_q)
            KIND_DIGIT: begin
              if (digit_ok) begin
                if (pending_q == OP_NONE) first_count_q <= first_count_q + 4'd1;
                else                      second_count_q <= second_count_q + 4'd1;
              end
            end
            KIND_OPERATOR: begin
              if (key_q <= KEY_EQUAL && (pending_q == OP_NONE || pending_q == OP_EQUAL)) begin
                pending_q <= key_q + 3'd1;
              end
            end
            KIND_CANCEL: begin
              if (pending_q == OP_NONE) first_count_q <= 4'd0;
              else                      second_count_q <= 4'd0;
            end
            default: begin
              first_count_q  <= 4'd0;
              second_count_q <= 4'd0;
              pending_q      <= OP_NONE;
              sign_q         <= 1'b0;
            end
          endcase
        end
        ST_CONV_B: begin
          if (state_d == ST_EMIT_CLR1) begin
            first_count_q <= 4'd0;
            sign_q        <= 1'b0;
          end
        end
        ST_CHECK: begin
          if (!alu_rsp.borrow) begin
            first_count_q <= 4'd0;
            sign_q        <= 1'b0;
          end
        end
        ST_EXTRACT: begin
          if (state_d == ST_EMIT_CLR1) begin
            first_count_q <= len_q + 4'd1;
            sign_q        <= neg_q;
          end
        end
        ST_EMIT_CLR2: begin
          if (can_emit) begin
            second_count_q <= 4'd0;
            pending_q      <= key_q + 3'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Key capture and arithmetic sequencing
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= s_axis_tuser;
      dig_q  <= s_axis_tdata[3:0];
      key_q  <= s_axis_tdata[6:4];
    end
    case (state_q)
      ST_DECODE: begin
        r_q   <= '0;
        idx_q <= 3'd0;
        ph_q  <= 1'b0;
        err_q <= 1'b0;
        if (kind_q == KIND_DIGIT && digit_ok) begin
          if (pending_q == OP_NONE) fd_q[first_count_q[2:0]] <= dig_q;
          else                      sd_q[second_count_q[2:0]] <= dig_q;
        end
      end
      ST_CONV_A, ST_CONV_B: begin
        if ((state_q == ST_CONV_A ? first_count_q : second_count_q) == 4'd0) begin
          if (state_q == ST_CONV_A) a_q <= '0;
          else                      b_q <= '0;
          r_q   <= '0;
          idx_q <= 3'd0;
          ph_q  <= 1'b0;
        end else begin
          r_q  <= alu_rsp.sum;
          ph_q <= ~ph_q;
          if (ph_q) begin
            if (state_q == ST_CONV_A ? idx_last_a : idx_last_b) begin
              if (state_q == ST_CONV_A) a_q <= alu_rsp.sum;
              else                      b_q <= alu_rsp.sum;
              r_q   <= '0;
              idx_q <= 3'd0;
            end else begin
              idx_q <= idx_q + 3'd1;
            end
          end
        end
        if (state_q == ST_CONV_B) begin
          neg_q <= sign_q;
          cnt_q <= 5'(OPW - 1);
          err_q <= (state_d == ST_EMIT_CLR1);
        end
      end
      ST_ADD: begin
        r_q <= alu_rsp.sum;
        if (plus) neg_q <= sign_q;
        else      neg_q <= alu_rsp.borrow;
      end
      ST_NEG: r_q <= alu_rsp.sum;
      ST_MUL: begin
        if (b_q != '0) begin
          r_q <= alu_rsp.sum;
          a_q <= {a_q[W-2:0], 1'b0};
          b_q <= {1'b0, b_q[W-1:1]};
        end
      end
      ST_DIV: begin
        r_q   <= alu_rsp.borrow ? rem_sh : alu_rsp.sum;
        a_q   <= {a_q[W-2:0], ~alu_rsp.borrow};
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          r_q <= W'({a_q[OPW-2:0], ~alu_rsp.borrow});
        end
      end
      ST_CHECK: begin
        err_q     <= ~alu_rsp.borrow;
        neg_q     <= neg_q & (r_q != '0);
        p_q       <= LIMIT_C - 4'd1;
        dg_q      <= 4'd0;
        len_q     <= 4'd0;
        started_q <= 1'b0;
      end
      ST_EXTRACT: begin
        if (!alu_rsp.borrow) begin
          r_q  <= alu_rsp.sum;
          dg_q <= dg_q + 4'd1;
        end else begin
          if (started_q || dg_q != 4'd0 || p_q == 4'd0) begin
            fd_q[len_q[2:0]] <= dg_q;
            started_q        <= 1'b1;
            if (p_q != 4'd0) len_q <= len_q + 4'd1;
          end
          dg_q <= 4'd0;
          if (p_q != 4'd0) p_q <= p_q - 4'd1;
          idx_q <= 3'd0;
        end
      end
      ST_EMIT_DIG: if (can_emit) idx_q <= idx_q + 3'd1;
      default: ;
    endcase
  end

endmodule

// ===== sim/kpc_checker.sv =====
// Checker for the keypad calculator core: watches key and display channels,
// predicts display requests per accepted key and compares them in order.
// Depends on kpc_pkg.
module kpc_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  input  logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,
  input  logic [1:0] s_axis_tuser,
  input  logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  input  logic [7:0] m_axis_tdata,
  input  logic [1:0] m_axis_tuser,
  input  logic       m_axis_tlast,
  output int         err_cnt_o,
  output int         pending_o,
  output int         disp_cnt_o,
  output int         calc_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import kpc_pkg::*;

  localparam int LIM = (MAX_DIGITS_DEF > DEPTH) ? DEPTH : MAX_DIGITS_DEF;

  typedef struct packed {
    logic [1:0] cmd;
    logic [3:0] val;
    logic       last;
  } disp_t;

  disp_t      disp_q[$];
  logic [3:0] a_dig[DEPTH];
  logic [3:0] b_dig[DEPTH];
  int         a_cnt, b_cnt;
  logic [2:0] pend;
  logic       a_neg;

  assign pending_o = disp_q.size();

  function automatic longint digs_val(input logic [3:0] d[DEPTH], input int n);
    longint v;
    v = 0;
    for (int i = 0; i < n; i++) v = v * 10 + d[i];
    return v;
  endfunction

  function automatic void push(input logic [1:0] c, input logic [3:0] v);
    disp_t e;
    e.cmd = c; e.val = v; e.last = 1'b0;
    disp_q.push_back(e);
  endfunction

  // Apply the pending arithmetic and queue its display requests
  function automatic void run_calc();
    longint a, b, r, mag;
    logic [3:0] tmp[DEPTH];
    int len;
    bit bad;
    a = digs_val(a_dig, a_cnt);
    b = digs_val(b_dig, b_cnt);
    r = 0; len = 0; bad = 0;
    if (a_neg) a = -a;
    case (pend)
      OP_ADD: r = a + b;
      OP_SUB: r = a - b;
      OP_DIV: if (b == 0) bad = 1; else r = a / b;
      default: r = a * b;
    endcase
    push(CMD_CLEAR, 4'd0);
    if (!bad) begin
      mag = (r < 0) ? -r : r;
      do begin
        if (len >= LIM) begin
          bad = 1;
          break;
        end
        tmp[len++] = 4'(mag % 10);
        mag = mag / 10;
      end while (mag != 0);
    end
    if (bad) begin
      a_cnt = 0; a_neg = 0;
      push(CMD_ERROR, 4'd0);
    end else begin
      a_neg = (r < 0);
      for (int i = 0; i < len; i++) a_dig[i] = tmp[len - 1 - i];
      a_cnt = len;
      push(CMD_SIGN, {3'd0, a_neg});
      for (int i = 0; i < len; i++) push(CMD_DIGIT, a_dig[i]);
    end
    b_cnt = 0;
  endfunction

  // Predict display requests for one key
  function automatic void predict_key(input logic [1:0] kind, input logic [3:0] dig,
                                      input logic [2:0] key);
    int n0;
    n0 = disp_q.size();
    case (kind)
      KIND_DIGIT: begin
        if (dig <= 9 && a_cnt < LIM && b_cnt < LIM) begin
          push(CMD_DIGIT, dig);
          if (pend == OP_NONE) a_dig[a_cnt++] = dig;
          else b_dig[b_cnt++] = dig;
        end
      end
      KIND_OPERATOR: begin
        if (key <= KEY_EQUAL) begin
          if (pend != OP_NONE && pend != OP_EQUAL) begin
            run_calc();
            calc_cnt_o++;
          end
          push(CMD_CLEAR, 4'd0);
          pend = key + 3'd1;
        end
      end
      KIND_CANCEL: begin
        push(CMD_CLEAR, 4'd0);
        if (pend == OP_NONE) a_cnt = 0;
        else b_cnt = 0;
      end
      default: begin
        a_cnt = 0; b_cnt = 0; pend = OP_NONE; a_neg = 0;
      end
    endcase
    if (disp_q.size() > n0) disp_q[$].last = 1'b1;
  endfunction

  initial begin
    err_cnt_o = 0; disp_cnt_o = 0; calc_cnt_o = 0;
    a_cnt = 0; b_cnt = 0; pend = OP_NONE; a_neg = 0;
  end

  always @(posedge clk_i) begin
    disp_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.cmd = m_axis_tuser; got.val = m_axis_tdata[3:0]; got.last = m_axis_tlast;
      disp_cnt_o++;
      if (disp_q.size() == 0) begin
        err_cnt_o++;
        $display("%0t: unexpected display request cmd=%0d val=%0d last=%0d",
                 $time, got.cmd, got.val, got.last);
      end else begin
        want = disp_q.pop_front();
        if (got !== want || m_axis_tdata[7:4] !== 4'd0) begin
          err_cnt_o++;
          $display("%0t: mismatch expected cmd=%0d val=%0d last=%0d, got cmd=%0d val=%0d last=%0d",
                   $time, want.cmd, want.val, want.last, got.cmd, got.val, got.last);
        end
      end
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      predict_key(s_axis_tuser, s_axis_tdata[3:0], s_axis_tdata[6:4]);
  end
endmodule

// ===== sim/tb.sv =====
// Top of the keypad calculator testbench: clock, reset, key stimulus with
// idle and stall phases, and the verdict. Depends on kpc_pkg, kpc_checker, the core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kpc_pkg::*;

  logic       clk_i = 0;
  logic       rst_ni = 0;
  logic       s_axis_tvalid = 0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 0;
  logic [1:0] s_axis_tuser = 0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 0;
  logic [7:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic       m_axis_tlast;
  int         err_cnt, pending, disp_cnt, calc_cnt;
  int         key_cnt = 0;
  int         src_idle = 0, snk_stall = 0;
  longint     cyc = 0;

  decimal_keypad_calculator_core DUT (.*);
  kpc_checker chk (.*, .err_cnt_o(err_cnt), .pending_o(pending),
                   .disp_cnt_o(disp_cnt), .calc_cnt_o(calc_cnt));

  initial forever #6 clk_i = ~clk_i;

  // Receiver stalls at the chosen rate
  always @(negedge clk_i) m_axis_tready <= ($urandom_range(99) >= snk_stall);

  // Run limit
  always @(posedge clk_i) begin
    cyc++;
    if (cyc > 2000000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Present one key and wait for its acceptance; valid drops only while idling
  task automatic send_key(input logic [1:0] kind, input logic [3:0] dig,
                          input logic [2:0] key);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {1'b0, key, dig};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    key_cnt++;
  endtask

  task automatic num_in(input int n);
    for (int i = 0; i < n; i++) send_key(KIND_DIGIT, 4'($urandom_range(9)), 3'($urandom));
  endtask

  // Random key mix: mostly digit runs and valid operators, some cancel, reset and invalid keys
  task automatic rand_key();
    int r;
    r = $urandom_range(99);
    if (r < 50) num_in($urandom_range(1, 4) + ($urandom_range(9) == 0 ? 5 : 0));
    else if (r < 80) send_key(KIND_OPERATOR, 4'($urandom), 3'($urandom_range(4)));
    else if (r < 86) send_key(KIND_CANCEL, 4'($urandom), 3'($urandom));
    else if (r < 89) send_key(KIND_RESET, 4'($urandom), 3'($urandom));
    else if (r < 94) send_key(KIND_DIGIT, 4'($urandom_range(10, 15)), 3'($urandom));
    else send_key(KIND_OPERATOR, 4'($urandom), 3'($urandom_range(5, 7)));
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);
    // Directed: long operands, overflow, divide by zero, negatives, ignored keys
    for (int i = 0; i < 9; i++) send_key(KIND_DIGIT, 4'd9, 3'd7);
    send_key(KIND_OPERATOR, 4'd15, 3'd3);
    for (int i = 0; i < 9; i++) send_key(KIND_DIGIT, 4'd9, 3'd0);
    send_key(KIND_OPERATOR, 4'd0, 3'd1);
    send_key(KIND_DIGIT, 4'd15, 3'd0);
    send_key(KIND_OPERATOR, 4'd0, 3'd7);
    send_key(KIND_DIGIT, 4'd3, 3'd0);
    send_key(KIND_OPERATOR, 4'd0, 3'd2);
    send_key(KIND_DIGIT, 4'd0, 3'd0);
    send_key(KIND_OPERATOR, 4'd0, 3'd1);
    send_key(KIND_DIGIT, 4'd5, 3'd0);
    send_key(KIND_OPERATOR, 4'd0, 3'd0);
    send_key(KIND_DIGIT, 4'd5, 3'd0);
    send_key(KIND_CANCEL, 4'd0, 3'd0);
    send_key(KIND_DIGIT, 4'd2, 3'd0);
    send_key(KIND_OPERATOR, 4'd0, 3'd4);
    send_key(KIND_CANCEL, 4'd0, 3'd0);
    send_key(KIND_RESET, 4'd0, 3'd0);
    // Random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      src_idle  = (ph == 1) ? 87 : (ph == 3) ? 33 : 0;
      snk_stall = (ph == 2) ? 87 : (ph == 3) ? 33 : 0;
      while (key_cnt < 30 + (ph + 1) * 70) rand_key();
    end
    s_axis_tvalid <= 1'b0;
    src_idle = 0; snk_stall = 0;
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    $display("Sent %0d keys, checked %0d display requests, %0d computing operator keys.",
             key_cnt, disp_cnt, calc_cnt);
    if (err_cnt == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
